@@ rtl/sid_pkg.sv @@
package sid_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_PARALLEL_THRESHOLD = 2'd0;
  localparam logic [CFG_DATA_W-1:0] PARALLEL_THRESHOLD_RST = 32'd1;

endpackage

@@ rtl/sid_if.sv @@
interface sid_seg_if #(
  parameter int CW = 16
) ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;
  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

interface sid_res_if #(
  parameter int CW = 16
) ();
  logic valid;
  logic ready;
  logic hit;
  logic is_parallel;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;
  modport source (output valid, hit, is_parallel, cross_x, cross_y, input ready);
  modport sink (input valid, hit, is_parallel, cross_x, cross_y, output ready);
endinterface

@@ rtl/sid_div.sv @@
// pipelined restoring divider: one quotient bit per stage, magnitude only
module sid_div #(
  parameter int NW = 36,
  parameter int DW = 36,
  parameter int QW = 18,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  logic [QW:0]         vld;
  logic [NW-1:0]       rem [QW+1];
  logic [DW-1:0]       dv  [QW+1];
  logic [QW-1:0]       qq  [QW+1];
  logic [TW-1:0]       tg  [QW+1];

  assign vld[0] = in_valid;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign qq[0]  = '0;
  assign tg[0]  = tag_in;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SH = QW - 1 - s;
    logic [NW+QW-1:0] trial;
    logic             ge;
    assign trial = {{QW{1'b0}}, dv[s]} << SH;
    assign ge    = {{QW{1'b0}}, rem[s]} >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? rem[s] - trial[NW-1:0] : rem[s];
        qq[s+1]  <= qq[s] | (QW'(ge) << SH);
        dv[s+1]  <= dv[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = qq[QW];
  assign tag_out   = tg[QW];
endmodule

@@ rtl/segment_intersection_2d_unit.sv @@
// Segment crossing test, fully pipelined: one segment pair is accepted every
// cycle while the result output is not stalled; the crossing point comes from
// two pipelined dividers, one quotient bit per stage. Backpressure stalls the
// whole pipeline at once. The crossing point is truncated toward zero and is
// zero unless hit is set; a denominator of magnitude below parallel_threshold,
// or zero, reports is_parallel.
module segment_intersection_2d_unit #(
  parameter int COORD_WIDTH = sid_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  sid_seg_if.sink                           seg,
  sid_res_if.source                         res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sid_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sid_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sid_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import sid_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DFW = CW + 1;
  localparam int PW = 2 * DFW;
  localparam int NW = PW + 1;
  localparam int MW = NW + DFW;
  localparam int QW = DFW;

  logic [CFG_DATA_W-1:0] thr;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PARALLEL_THRESHOLD) ? thr : '0;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= PARALLEL_THRESHOLD_RST;
    end else if (psel && penable && pwrite && paddr == REG_PARALLEL_THRESHOLD) begin
      thr <= pwdata;
    end
  end

  logic en;
  logic out_vld;
  assign en = !out_vld || res.ready;
  assign seg.ready = en;

  // stage 1: differences
  logic              v1;
  logic signed [DFW-1:0] abx, aby, cdx, cdy, acx, acy;
  logic signed [CW-1:0]  ax1, ay1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= seg.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      abx <= DFW'(seg.first_end_x) - DFW'(seg.first_start_x);
      aby <= DFW'(seg.first_end_y) - DFW'(seg.first_start_y);
      cdx <= DFW'(seg.second_end_x) - DFW'(seg.second_start_x);
      cdy <= DFW'(seg.second_end_y) - DFW'(seg.second_start_y);
      acx <= DFW'(seg.first_start_x) - DFW'(seg.second_start_x);
      acy <= DFW'(seg.first_start_y) - DFW'(seg.second_start_y);
      ax1 <= seg.first_start_x;
      ay1 <= seg.first_start_y;
    end
  end

  // stage 2: six products
  logic v2;
  logic signed [PW-1:0] p_d0, p_d1, p_a0, p_a1, p_b0, p_b1;
  logic signed [DFW-1:0] abx2, aby2;
  logic signed [CW-1:0] ax2, ay2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_d0 <= abx * cdy;
      p_d1 <= aby * cdx;
      p_a0 <= acy * cdx;
      p_a1 <= acx * cdy;
      p_b0 <= acy * abx;
      p_b1 <= acx * aby;
      abx2 <= abx; aby2 <= aby; ax2 <= ax1; ay2 <= ay1;
    end
  end

  // stage 3: d, na, nb normalized to positive d, tests
  logic signed [NW-1:0] d_w, na_w, nb_w, dp_w, nap_w, nbp_w;
  logic [NW-1:0] dmag_w;
  logic par_w, hit_w;
  always_comb begin
    d_w  = NW'(p_d0) - NW'(p_d1);
    na_w = NW'(p_a0) - NW'(p_a1);
    nb_w = NW'(p_b0) - NW'(p_b1);
    dmag_w = d_w[NW-1] ? -d_w : d_w;
    par_w = (dmag_w == '0) || (dmag_w < NW'(thr)) && (NW >= CFG_DATA_W)
            || (NW < CFG_DATA_W) && ({{CFG_DATA_W{1'b0}}, dmag_w} < {{NW{1'b0}}, thr});
    dp_w  = d_w[NW-1] ? -d_w : d_w;
    nap_w = d_w[NW-1] ? -na_w : na_w;
    nbp_w = d_w[NW-1] ? -nb_w : nb_w;
    hit_w = !par_w && !nap_w[NW-1] && (nap_w <= dp_w) && !nbp_w[NW-1] && (nbp_w <= dp_w);
  end
  logic v3, par3, hit3;
  logic signed [NW-1:0] na3;
  logic [NW-1:0] d3;
  logic signed [DFW-1:0] abx3, aby3;
  logic signed [CW-1:0] ax3, ay3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      par3 <= par_w; hit3 <= hit_w; na3 <= nap_w; d3 <= dp_w;
      abx3 <= abx2; aby3 <= aby2; ax3 <= ax2; ay3 <= ay2;
    end
  end

  // stage 4: offset products, magnitudes
  logic v4, par4, hit4, sx4, sy4;
  logic [MW-1:0] mx4, my4;
  logic [NW-1:0] d4;
  logic signed [CW-1:0] ax4, ay4;
  logic signed [MW-1:0] px_w, py_w;
  assign px_w = MW'(na3) * MW'(abx3);
  assign py_w = MW'(na3) * MW'(aby3);
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx4 <= px_w[MW-1]; sy4 <= py_w[MW-1];
      mx4 <= px_w[MW-1] ? -px_w : px_w;
      my4 <= py_w[MW-1] ? -py_w : py_w;
      d4 <= d3; par4 <= par3; hit4 <= hit3; ax4 <= ax3; ay4 <= ay3;
    end
  end

  localparam int TW = 3 + 2 * CW + 2;
  logic [TW-1:0] tag_i, tag_o;
  logic [QW-1:0] qx, qy;
  logic dv_x, dv_y;
  assign tag_i = {v4, par4, hit4, ax4, ay4, sx4, sy4};
  sid_div #(.NW(MW), .DW(NW), .QW(QW), .TW(TW)) u_div_x (
    .clk, .rst, .en, .in_valid(v4), .num(mx4), .den(d4), .tag_in(tag_i),
    .out_valid(dv_x), .quo(qx), .tag_out(tag_o));
  sid_div #(.NW(MW), .DW(NW), .QW(QW), .TW(1)) u_div_y (
    .clk, .rst, .en, .in_valid(v4), .num(my4), .den(d4), .tag_in(1'b0),
    .out_valid(dv_y), .quo(qy), .tag_out());

  logic par6, hit6, sx6, sy6;
  logic signed [CW-1:0] ax6, ay6;
  assign {par6, hit6, ax6, ay6, sx6, sy6} = tag_o[TW-2:0];
  logic signed [CW-1:0] ox, oy;
  assign ox = sx6 ? -CW'(qx) : CW'(qx);
  assign oy = sy6 ? -CW'(qy) : CW'(qy);

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= dv_x;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res.hit <= hit6;
      res.is_parallel <= par6;
      res.cross_x <= hit6 ? ax6 + ox : '0;
      res.cross_y <= hit6 ? ay6 + oy : '0;
    end
  end
  assign res.valid = out_vld;

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) dv_x == dv_y)
    else $error("divider lanes out of step");
  a_tag_valid: assert property (@(posedge clk) disable iff (rst) dv_x |-> tag_o[TW-1])
    else $error("tag valid mismatch");
  a_hit_not_par: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.hit && res.is_parallel))
    else $error("hit while parallel");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.hit) |-> (res.cross_x == '0 && res.cross_y == '0))
    else $error("miss with nonzero point");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid)
    else $error("result dropped");
endmodule

@@ verif/sid_checker.sv @@
module sid_checker #(
  parameter int CW = 16
) (
  input  logic clk,
  input  logic rst,
  sid_seg_if.sink seg_mon,
  sid_res_if.sink res_mon,
  input  logic [31:0] threshold,
  output int fail_count,
  output int pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic hit;
    logic par;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic logic signed [63:0] trunc_div(logic signed [63:0] p,
                                                   logic signed [63:0] dpos);
    logic [63:0] m;
    logic [63:0] q;
    m = p[63] ? -p : p;
    q = m / dpos;
    return p[63] ? -q : q;
  endfunction

  function automatic crossing_t predict_crossing(
      logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
      logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
      logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
      logic signed [CW-1:0] dx, logic signed [CW-1:0] dy,
      logic [31:0] thr);
    logic signed [63:0] abx, aby, cdx, cdy, acx, acy, den, na, nb, dmag, ox, oy;
    crossing_t r;
    abx = 64'(bx) - 64'(ax);
    aby = 64'(by) - 64'(ay);
    cdx = 64'(dx) - 64'(cx);
    cdy = 64'(dy) - 64'(cy);
    acx = 64'(ax) - 64'(cx);
    acy = 64'(ay) - 64'(cy);
    den = abx * cdy - aby * cdx;
    na = acy * cdx - acx * cdy;
    nb = acy * abx - acx * aby;
    dmag = den < 0 ? -den : den;
    r = '0;
    r.par = (dmag == 0) || (dmag < $signed({32'd0, thr}));
    if (!r.par) begin
      if (den < 0) begin
        den = -den;
        na = -na;
        nb = -nb;
      end
      r.hit = na >= 0 && na <= den && nb >= 0 && nb <= den;
      if (r.hit) begin
        ox = 64'(ax) + trunc_div(na * abx, den);
        oy = 64'(ay) + trunc_div(na * aby, den);
        r.px = ox[CW-1:0];
        r.py = oy[CW-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    crossing_t w;
    if (!rst) begin
      if (seg_mon.valid && seg_mon.ready)
        crossing_q.push_back(predict_crossing(seg_mon.first_start_x, seg_mon.first_start_y,
          seg_mon.first_end_x, seg_mon.first_end_y, seg_mon.second_start_x,
          seg_mon.second_start_y, seg_mon.second_end_x, seg_mon.second_end_y, threshold));
      if (res_mon.valid && res_mon.ready) begin
        if (crossing_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          w = crossing_q.pop_front();
          if (res_mon.hit !== w.hit)
            report_mismatch("hit", int'(res_mon.hit), int'(w.hit));
          if (res_mon.is_parallel !== w.par)
            report_mismatch("is_parallel", int'(res_mon.is_parallel), int'(w.par));
          if (res_mon.cross_x !== w.px)
            report_mismatch("cross_x", int'(res_mon.cross_x), int'(w.px));
          if (res_mon.cross_y !== w.py)
            report_mismatch("cross_y", int'(res_mon.cross_y), int'(w.py));
        end
      end
      pending_count = crossing_q.size();
    end
  end
endmodule

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sid_pkg::*;

  localparam int CW = 16;
  localparam int LATENCY = CW + 6;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic [31:0] threshold = PARALLEL_THRESHOLD_RST;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit hold_res = 0;
  bit stim_done = 0;

  sid_seg_if #(.CW(CW)) seg ();
  sid_res_if #(.CW(CW)) res ();

  segment_intersection_2d_unit #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst(rst), .seg(seg.sink), .res(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sid_checker #(.CW(CW)) u_checker (
    .clk(clk), .rst(rst), .seg_mon(seg.sink), .res_mon(res.sink),
    .threshold(threshold), .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin
    seg.valid = 0;
    {seg.first_start_x, seg.first_start_y, seg.first_end_x, seg.first_end_y} = '0;
    {seg.second_start_x, seg.second_start_y, seg.second_end_x, seg.second_end_y} = '0;
    res.ready = 0;
  end

  // receiver
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if (hold_res) begin
        res.ready <= 0;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        res.ready <= 0;
        repeat (g > 0 ? g : 1) @(negedge clk);
      end else begin
        res.ready <= 1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((seg.valid && seg.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("segment_intersection_2d_unit test failed");
      $finish;
    end
  end

  task automatic write_threshold(logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_PARALLEL_THRESHOLD; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    threshold <= v;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_pair(logic [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy);
    seg.first_start_x <= ax; seg.first_start_y <= ay;
    seg.first_end_x <= bx; seg.first_end_y <= by;
    seg.second_start_x <= cx; seg.second_start_y <= cy;
    seg.second_end_x <= dx; seg.second_end_y <= dy;
    seg.valid <= 1;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      seg.valid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    seg.valid <= 0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rnd_coord(int span);
    case ($urandom_range(0, 5))
      0: return CW'($urandom);
      1: return CW'(16'sh7fff - $urandom_range(0, 3));
      2: return CW'(16'sh8000 + $urandom_range(0, 3));
      default: return CW'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  task automatic random_pair(int span);
    logic [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    int m;
    ax = rnd_coord(span); ay = rnd_coord(span);
    bx = rnd_coord(span); by = rnd_coord(span);
    m = $urandom_range(0, 9);
    if (m < 5) begin
      // c-d straddles a-b around its midpoint so a crossing is likely
      cx = CW'((ax + bx) / 2 + $urandom_range(0, 400) - 200);
      cy = CW'((ay + by) / 2 + $urandom_range(0, 400) - 200);
      dx = CW'(2 * ((ax + bx) / 2) - cx + $urandom_range(0, 8) - 4);
      dy = CW'(2 * ((ay + by) / 2) - cy + $urandom_range(0, 8) - 4);
    end else if (m < 7) begin
      // parallel or near parallel
      cx = rnd_coord(span); cy = rnd_coord(span);
      dx = CW'(cx + (bx - ax) + $urandom_range(0, 2) - 1);
      dy = cy + (by - ay);
    end else if (m == 7) begin
      // shared endpoint
      cx = bx; cy = by; dx = rnd_coord(span); dy = rnd_coord(span);
    end else begin
      cx = rnd_coord(span); cy = rnd_coord(span);
      dx = rnd_coord(span); dy = rnd_coord(span);
    end
    send_pair(ax, ay, bx, by, cx, cy, dx, dy);
  endtask

  initial begin
    logic [31:0] thr_list[5];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    repeat (2) @(negedge clk);

    // directed: crossing, endpoint touches, parallel, collinear, extremes
    send_pair(16'h0000, 16'h0000, 16'h0400, 16'h0400, 16'h0000, 16'h0400, 16'h0400, 16'h0000);
    send_pair(16'h0000, 16'h0000, 16'h0200, 16'h0000, 16'h0200, 16'hff00, 16'h0200, 16'h0100);
    send_pair(16'h0000, 16'h0000, 16'h0200, 16'h0000, 16'h0000, 16'hff00, 16'h0000, 16'h0100);
    send_pair(16'h0000, 16'h0000, 16'h0200, 16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'h0100);
    send_pair(16'h0000, 16'h0000, 16'h0200, 16'h0000, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_pair(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0300, 16'h0000, 16'h0300, 16'h0100);
    send_pair(16'h0001, 16'h0003, 16'h0007, 16'hfffd, 16'h0000, 16'h0000, 16'h0005, 16'h0002);
    send_pair(16'hffff, 16'hffff, 16'hfff0, 16'h0011, 16'hfff5, 16'hfff5, 16'h0000, 16'h0009);
    send_pair(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    drain();

    // threshold zero: only an exact zero denominator is parallel
    write_threshold(32'd0);
    send_pair(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_pair(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100);
    drain();
    write_threshold(32'hffffffff);
    send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_threshold(32'd1);
    fork
      begin
        hold_res = 1;
        repeat (300) @(negedge clk);
        hold_res = 0;
      end
      begin
        repeat (80) random_pair(3000);
      end
    join
    drain();

    thr_list = '{32'd1, 32'd0, 32'd65536, 32'h00ffffff, 32'hffffffff};
    foreach (thr_list[k]) begin
      write_threshold(thr_list[k]);
      for (int i = 0; i < 260; i++) begin
        random_pair(i % 3 == 0 ? 32767 : (i % 3 == 1 ? 2000 : 60));
        if ($urandom_range(0, 2) == 0) send_gap();
        else if (i % 50 == 25) begin
          seg.valid <= 0;
          repeat ($urandom_range(30, 60)) @(negedge clk);
        end
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) begin
      $display("segment_intersection_2d_unit test passed");
    end else begin
      $display("segment_intersection_2d_unit test failed");
    end
    $finish;
  end
endmodule

@@ segment_intersection_2d_unit.f @@
rtl/sid_pkg.sv
rtl/sid_if.sv
rtl/sid_div.sv
rtl/segment_intersection_2d_unit.sv
verif/sid_checker.sv
verif/testbench.sv
